// ===== src/premultiplied_gamma_two_correct_unit_assert.svh =====
`ifndef PREMULTIPLIED_GAMMA_TWO_CORRECT_UNIT_ASSERT_SVH
`define PREMULTIPLIED_GAMMA_TWO_CORRECT_UNIT_ASSERT_SVH

// checked outside reset
`define PGTC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pgtc assertion failed");

// checked in reset too
`define PGTC_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("pgtc reset assertion failed");

`endif

// ===== src/pgtc_pkg.sv =====
package pgtc_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int CHAN_W = 23;
    localparam int WORD_W = 24;

    typedef struct packed {
        logic              use_alpha;
        logic              dir;
        logic              zero;
        logic [CHAN_W-1:0] alpha;
    } t_side;

    function automatic int pipe_depth(input int f);
        return 2 * f + 40;
    endfunction

endpackage

// ===== src/pgtc_lane.sv =====
module pgtc_lane #(
    parameter int FRACTION_BITS = pgtc_pkg::FRACTION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [pgtc_pkg::CHAN_W-1:0] i_x,
    input  pgtc_pkg::t_side             i_side,
    output logic [pgtc_pkg::CHAN_W-1:0] o_y
);
    localparam int F  = FRACTION_BITS;
    localparam int XW = pgtc_pkg::CHAN_W;
    localparam int QW = XW + F;
    localparam int CW = 12 + F;
    localparam int LO = CW / 2;
    localparam int HI = CW - LO;
    localparam int RW = 12 + F;
    localparam int MW = 2 * RW;
    localparam int SW = 2 * CW;
    localparam int VW = 23 + F;
    localparam int VH = VW - 24;
    localparam int PW = VW + XW;
    localparam int YW = PW - F;
    localparam logic [XW-1:0] CAP = {XW{1'b1}};

    // divide stages
    logic [XW-1:0]         r_rem [QW+1];
    logic [QW-1:0]         r_nq  [QW+1];
    logic [XW-1:0]         r_x   [QW+1];
    pgtc_pkg::t_side       r_sd  [QW+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_nq[0]  <= {i_x, {F{1'b0}}};
            r_x[0]   <= i_x;
            r_sd[0]  <= i_side;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [XW:0] t;
        logic [XW:0] d;
        logic        ge;
        assign t  = {r_rem[k], r_nq[k][QW-1]};
        assign ge = t >= {1'b0, r_sd[k].alpha};
        assign d  = t - {1'b0, r_sd[k].alpha};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? d[XW-1:0] : t[XW-1:0];
                r_nq[k+1]  <= {r_nq[k][QW-2:0], ge};
                r_x[k+1]   <= r_x[k];
                r_sd[k+1]  <= r_sd[k];
            end
        end
    end

    logic [QW-1:0] c;
    assign c = r_sd[QW].use_alpha ? r_nq[QW] : {{F{1'b0}}, r_x[QW]};

    // root stages, square alongside
    logic [RW:0]     r_rr   [RW+1];
    logic [RW-1:0]   r_root [RW+1];
    logic [MW-1:0]   r_val  [RW+1];
    pgtc_pkg::t_side r_rs   [RW+1];
    logic [2*HI-1:0] r_ph;
    logic [CW-1:0]   r_pm;
    logic [2*LO-1:0] r_pl;
    logic            r_satc;
    logic [VW-1:0]   r_vsq  [RW];
    logic            r_vsat [RW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rr[0]   <= '0;
            r_root[0] <= '0;
            r_val[0]  <= {1'b0, c, {F{1'b0}}};
            r_rs[0]   <= r_sd[QW];
            r_ph      <= c[CW-1:LO] * c[CW-1:LO];
            r_pm      <= c[CW-1:LO] * c[LO-1:0];
            r_pl      <= c[LO-1:0] * c[LO-1:0];
            r_satc    <= |c[QW-1:CW];
        end
    end

    logic [SW-1:0]   sq;
    logic [SW-F-1:0] vsq_full;
    assign sq = (SW'(r_ph) << (2 * LO)) + (SW'(r_pm) << (LO + 1)) + SW'(r_pl);
    assign vsq_full = sq[SW-1:F];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vsq[0]  <= vsq_full[VW-1:0];
            r_vsat[0] <= r_satc | vsq_full[VW];
        end
    end

    for (genvar k = 1; k < RW; k++) begin : g_sqd
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_vsq[k]  <= r_vsq[k-1];
                r_vsat[k] <= r_vsat[k-1];
            end
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_root
        logic [RW+2:0] t;
        logic [RW+2:0] trial;
        logic [RW+2:0] d;
        logic          ge;
        assign t     = {r_rr[k], r_val[k][MW-1:MW-2]};
        assign trial = {1'b0, r_root[k], 2'b01};
        assign ge    = t >= trial;
        assign d     = t - trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rr[k+1]   <= ge ? d[RW:0] : t[RW:0];
                r_root[k+1] <= {r_root[k][RW-2:0], ge};
                r_val[k+1]  <= {r_val[k][MW-3:0], 2'b00};
                r_rs[k+1]   <= r_rs[k];
            end
        end
    end

    // select, premultiply, saturate
    logic [VW-1:0]   r_v;
    logic            r_vs;
    pgtc_pkg::t_side r_vside;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v     <= r_rs[RW].dir ? {{(VW-RW){1'b0}}, r_root[RW]} : r_vsq[RW-1];
            r_vs    <= r_rs[RW].dir ? 1'b0 : r_vsat[RW-1];
            r_vside <= r_rs[RW];
        end
    end

    logic [24+XW-1:0] r_ml;
    logic [VH+XW-1:0] r_mh;
    logic [VW-1:0]    r_mv;
    logic             r_ms;
    pgtc_pkg::t_side  r_mside;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ml    <= r_v[23:0] * r_vside.alpha;
            r_mh    <= r_v[VW-1:24] * r_vside.alpha;
            r_mv    <= r_v;
            r_ms    <= r_vs;
            r_mside <= r_vside;
        end
    end

    logic [PW-1:0] p;
    logic [YW-1:0] y;
    logic [XW-1:0] res;
    assign p = (PW'(r_mh) << 24) + PW'(r_ml);
    assign y = p[PW-1:F];

    always_comb begin
        if (r_mside.zero) begin
            res = '0;
        end else if (r_ms) begin
            res = CAP;
        end else if (r_mside.use_alpha) begin
            res = (|y[YW-1:XW]) ? CAP : y[XW-1:0];
        end else begin
            res = (|r_mv[VW-1:XW]) ? CAP : r_mv[XW-1:0];
        end
    end

    logic [XW-1:0] r_y;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= res;
        end
    end

    assign o_y = r_y;

endmodule

// ===== src/premultiplied_gamma_two_correct_unit.sv =====
// throughput: one pixel per cycle while the output is not stalled, set by the
// one-bit-per-stage divide and root chains
// the whole pipe holds while an output beat waits for ready
// reset (synchronous, active low) clears all valid bits and sets direction to square
module premultiplied_gamma_two_correct_unit #(
    parameter int FRACTION_BITS = pgtc_pkg::FRACTION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [pgtc_pkg::WORD_W-1:0] i_red_in,
    input  logic [pgtc_pkg::WORD_W-1:0] i_green_in,
    input  logic [pgtc_pkg::WORD_W-1:0] i_blue_in,
    input  logic [pgtc_pkg::WORD_W-1:0] i_alpha_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [pgtc_pkg::CHAN_W-1:0] o_red_out,
    output logic [pgtc_pkg::CHAN_W-1:0] o_green_out,
    output logic [pgtc_pkg::CHAN_W-1:0] o_blue_out,
    output logic [pgtc_pkg::WORD_W-1:0] o_alpha_out
);
    localparam int DEPTH = pgtc_pkg::pipe_depth(FRACTION_BITS);
    localparam int CW    = pgtc_pkg::CHAN_W;

    logic r_direction;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_direction <= i_cfg_wr_data;
        end
    end

    logic en;
    logic accept;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;
    assign accept  = i_valid && en;

    logic use_alpha;
    assign use_alpha = !i_alpha_in[CW] && (|i_alpha_in[CW-1:0]);

    pgtc_pkg::t_side side_r, side_g, side_b;
    always_comb begin
        side_r.use_alpha = use_alpha;
        side_r.dir       = r_direction;
        side_r.alpha     = i_alpha_in[CW-1:0];
        side_r.zero      = i_red_in[CW] || !(|i_red_in[CW-1:0]);
        side_g           = side_r;
        side_g.zero      = i_green_in[CW] || !(|i_green_in[CW-1:0]);
        side_b           = side_r;
        side_b.zero      = i_blue_in[CW] || !(|i_blue_in[CW-1:0]);
    end

    logic                        r_vld   [DEPTH];
    logic [pgtc_pkg::WORD_W-1:0] r_alpha [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_alpha[0] <= i_alpha_in;
        end
    end

    for (genvar k = 1; k < DEPTH; k++) begin : g_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_alpha[k] <= r_alpha[k-1];
            end
        end
    end

    pgtc_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_r (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (i_red_in[CW-1:0]),
        .i_side (side_r),
        .o_y    (o_red_out)
    );

    pgtc_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_g (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (i_green_in[CW-1:0]),
        .i_side (side_g),
        .o_y    (o_green_out)
    );

    pgtc_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (i_blue_in[CW-1:0]),
        .i_side (side_b),
        .o_y    (o_blue_out)
    );

    assign o_valid     = r_vld[DEPTH-1];
    assign o_alpha_out = r_alpha[DEPTH-1];

endmodule

// ===== src/pgtc_checker.sv =====
`include "premultiplied_gamma_two_correct_unit_assert.svh"

module pgtc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [pgtc_pkg::CHAN_W-1:0] o_red_out,
    input logic [pgtc_pkg::CHAN_W-1:0] o_green_out,
    input logic [pgtc_pkg::CHAN_W-1:0] o_blue_out,
    input logic [pgtc_pkg::WORD_W-1:0] o_alpha_out
);
    logic [3*pgtc_pkg::CHAN_W+pgtc_pkg::WORD_W-1:0] out_beat;
    assign out_beat = {o_red_out, o_green_out, o_blue_out, o_alpha_out};

    // stalled output beat holds
    `PGTC_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(out_beat))
    // empty output stage never blocks the input
    `PGTC_ASSERT(a_ready_when_empty, !o_valid |-> o_ready)
    // stalled output blocks the input
    `PGTC_ASSERT(a_block_on_stall, o_valid && !i_ready |-> !o_ready)
    `PGTC_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_valid)

endmodule

bind premultiplied_gamma_two_correct_unit pgtc_checker u_pgtc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out),
    .o_alpha_out (o_alpha_out)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    localparam int FB = pgtc_pkg::FRACTION_BITS_DEF;
    localparam int CW = pgtc_pkg::CHAN_W;
    localparam int WW = pgtc_pkg::WORD_W;
    localparam int PIPE_LAT = pgtc_pkg::pipe_depth(FB);
    localparam int STALL_LIMIT = 20000;
    localparam logic DIR_SQUARE = 1'b0;
    localparam logic DIR_ROOT = 1'b1;
    localparam logic [CW-1:0] CHAN_SAT = {CW{1'b1}};

    typedef struct packed {
        logic [CW-1:0] red;
        logic [CW-1:0] green;
        logic [CW-1:0] blue;
        logic [WW-1:0] alpha;
    } t_pixel_out;

    logic i_clk, i_rst_n;
    logic i_cfg_wr_en, i_cfg_wr_data;
    logic i_valid, o_ready, o_valid, i_ready;
    logic [WW-1:0] i_red_in, i_green_in, i_blue_in, i_alpha_in;
    logic [CW-1:0] o_red_out, o_green_out, o_blue_out;
    logic [WW-1:0] o_alpha_out;

    premultiplied_gamma_two_correct_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_red_in(i_red_in), .i_green_in(i_green_in),
        .i_blue_in(i_blue_in), .i_alpha_in(i_alpha_in),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_red_out(o_red_out), .o_green_out(o_green_out),
        .o_blue_out(o_blue_out), .o_alpha_out(o_alpha_out)
    );

    logic gamma_dir;
    t_pixel_out pixel_q[$];
    int n_errors = 0;
    int idle_cycles = 0;
    bit hold_off;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // floor(sqrt(v)), v < 2^64
    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [127:0] t;
        r = 0;
        for (int b = 35; b >= 0; b--) begin
            t = (r | (64'd1 << b)) * (r | (64'd1 << b));
            if (t <= {64'd0, v}) r = r | (64'd1 << b);
        end
        return r;
    endfunction

    function automatic logic [CW-1:0] correct_channel(input logic [WW-1:0] x,
            input logic [WW-1:0] a, input bit use_a, input logic dir);
        logic [127:0] c, v, y;
        if (x == 0 || x[WW-1]) return '0;
        c = use_a ? ({104'd0, x} << FB) / {104'd0, a} : {104'd0, x};
        if (dir == DIR_SQUARE) begin
            v = (c * c) >> FB;
            if (v > 128'hFFFF_FFFF_FFFF_FFFF) v = 128'hFFFF_FFFF_FFFF_FFFF;
        end else begin
            v = {64'd0, isqrt(c[63:0] << FB)};
        end
        y = use_a ? (v * a) >> FB : v;
        if (y > {105'd0, CHAN_SAT}) return CHAN_SAT;
        return y[CW-1:0];
    endfunction

    function automatic t_pixel_out correct_pixel(input logic [WW-1:0] r,
            input logic [WW-1:0] g, input logic [WW-1:0] b,
            input logic [WW-1:0] a);
        t_pixel_out p;
        bit use_a;
        use_a = a != 0 && !a[WW-1];
        p.red = correct_channel(r, a, use_a, gamma_dir);
        p.green = correct_channel(g, a, use_a, gamma_dir);
        p.blue = correct_channel(b, a, use_a, gamma_dir);
        p.alpha = a;
        return p;
    endfunction

    task automatic send_pixel(input logic [WW-1:0] r, input logic [WW-1:0] g,
            input logic [WW-1:0] b, input logic [WW-1:0] a);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 12));
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_red_in <= r;
        i_green_in <= g;
        i_blue_in <= b;
        i_alpha_in <= a;
        do @(posedge i_clk); while (!o_ready);
        pixel_q.push_back(correct_pixel(r, g, b, a));
        @(negedge i_clk);
    endtask

    task automatic drain_and_set_dir(input logic dir);
        i_valid <= 1'b0;
        while (pixel_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 4) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= dir;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        gamma_dir = dir;
    endtask

    function automatic logic [WW-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 24'h7FFFFF;
            2: return 24'h800000;
            3: return 24'h010000;
            4: return WW'($urandom_range(0, 24'h1FFFF));
            5: return WW'(24'hFFFFFF - $urandom_range(0, 255));
            default: return WW'($urandom);
        endcase
    endfunction

    function automatic logic [WW-1:0] rand_alpha();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 24'h010000;
            2: return WW'(24'h800000 | $urandom);
            3: return WW'($urandom_range(1, 255));
            default: return WW'($urandom_range(1, 24'h7FFFFF));
        endcase
    endfunction

    task automatic test_corners(input logic dir);
        drain_and_set_dir(dir);
        send_pixel(24'h000000, 24'h7FFFFF, 24'h800000, 24'h000000);
        send_pixel(24'h010000, 24'h000001, 24'hFFFFFF, 24'h000000);
        send_pixel(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h000001);
        send_pixel(24'h000001, 24'h010000, 24'h008000, 24'h010000);
        send_pixel(24'h004000, 24'h020000, 24'h7FFFFF, 24'h7FFFFF);
        send_pixel(24'h123456, 24'h800000, 24'h000001, 24'h800000);
        send_pixel(24'h008000, 24'h010000, 24'h000000, 24'hFFFFFF);
        send_pixel(24'h100000, 24'h555555, 24'h2AAAAA, 24'h008000);
    endtask

    task automatic test_random(input logic dir, input int n);
        drain_and_set_dir(dir);
        repeat (n) send_pixel(rand_word(), rand_word(), rand_word(), rand_alpha());
    endtask

    task automatic test_backpressure();
        drain_and_set_dir(DIR_ROOT);
        hold_off = 1'b1;
        repeat (150) send_pixel(rand_word(), rand_word(), rand_word(), rand_alpha());
    endtask

    // output side
    initial begin
        int wait_n;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 12));
            if (wait_n != 0) begin
                i_ready <= 1'b0;
                repeat (wait_n) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        t_pixel_out exp_px;
        if (i_rst_n && o_valid && i_ready) begin
            if (pixel_q.size() == 0) begin
                $error("unexpected beat");
                n_errors++;
            end else begin
                exp_px = pixel_q.pop_front();
                if (o_red_out !== exp_px.red) begin
                    $error("red_out exp %h got %h", exp_px.red, o_red_out);
                    n_errors++;
                end
                if (o_green_out !== exp_px.green) begin
                    $error("green_out exp %h got %h", exp_px.green, o_green_out);
                    n_errors++;
                end
                if (o_blue_out !== exp_px.blue) begin
                    $error("blue_out exp %h got %h", exp_px.blue, o_blue_out);
                    n_errors++;
                end
                if (o_alpha_out !== exp_px.alpha) begin
                    $error("alpha_out exp %h got %h", exp_px.alpha, o_alpha_out);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        hold_off = 1'b0;
        gamma_dir = DIR_SQUARE;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 1'b0;
        i_valid = 1'b0;
        i_red_in = '0;
        i_green_in = '0;
        i_blue_in = '0;
        i_alpha_in = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_corners(DIR_SQUARE);
        test_corners(DIR_ROOT);
        test_random(DIR_SQUARE, 400);
        test_random(DIR_ROOT, 400);
        test_backpressure();
        test_random(DIR_SQUARE, 130);
        i_valid <= 1'b0;
        while (pixel_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 4) @(negedge i_clk);
        if (n_errors == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end
endmodule
